/* hdl/tpm_pkg.sv */
// ---------------------------------------------------------------------------
// tpm_pkg: shared types and constants for the three-phase modulation command
// Configuration record, mode codes, register indexes and the quarter-wave
// sine table generator used at elaboration.
// ---------------------------------------------------------------------------
package tpm_pkg;

  // modulation modes
  typedef enum logic [1:0] {
    MODE_SINE   = 2'd0,
    MODE_MINMAX = 2'd1,
    MODE_DPWM   = 2'd2,
    MODE_ZERO   = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [7:0] REG_PHASE_STEP   = 8'd0;
  localparam logic [7:0] REG_PHASE_OFFSET = 8'd1;
  localparam logic [7:0] REG_MOD_INDEX    = 8'd2;
  localparam logic [7:0] REG_MOD_MODE     = 8'd3;

  localparam logic [14:0] MOD_INDEX_RST = 15'd16384;
  localparam logic [31:0] THIRD_TURN    = 32'h5555_5555;
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
  localparam logic [14:0] ONE_Q14       = 15'd16384;
  localparam logic signed [18:0] CMD_MAX = 19'sd131071;
  localparam logic signed [18:0] CMD_MIN = -19'sd131072;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] phase_offset;
    logic [14:0] mod_index;
    mode_t       mod_mode;
  } cfg_t;

  // term * x^2 in Q2.30
  function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // sin(pi/2 * k / 2^(abits-2)) by Taylor series in Q2.30, rounded to Q1.14
  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned abits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (HALF_PI_Q30 * 64'(k)) >> (abits - 2);
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd20;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd72;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = sq_step(term, x) / 64'd156;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    r = (sum + 64'd32768) >> 16;
    if (r > 64'(ONE_Q14)) begin
      r = 64'(ONE_Q14);
    end
    return r[14:0];
  endfunction

endpackage

/* hdl/tpm_front.sv */
// ---------------------------------------------------------------------------
// tpm_front: tick intake and phase classification
// Forms the phase angle from the tick, then splits the three phase angles
// into quarter-table index and sign for the back end.
// ---------------------------------------------------------------------------
module tpm_front #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpm_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_time_ticks,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [3*SINE_ADDR_BITS-1:0]   push_data
);

  localparam int A = SINE_ADDR_BITS;
  localparam logic [A-2:0] QLEN_V = {1'b1, {(A-2){1'b0}}};

  logic [31:0] prod;
  logic [31:0] phase_nxt;
  logic [31:0] phase_r;
  logic        valid_r;
  logic        take;

  // sign bit and mirrored quarter-table index for one phase angle
  function automatic logic [A-1:0] classify(input logic [31:0] ph);
    logic [A-1:0] addr;
    logic [A-2:0] ridx;
    addr = ph[31 -: A];
    if (addr[A-2]) begin
      ridx = QLEN_V - {1'b0, addr[A-3:0]};
    end else begin
      ridx = {1'b0, addr[A-3:0]};
    end
    return {addr[A-1], ridx};
  endfunction

  // phase = step * t + offset, modulo one turn; only the low word matters
  assign prod      = 32'(cfg.phase_step * in_time_ticks);
  assign phase_nxt = prod + {cfg.phase_offset, 16'h0000};

  assign in_ready = !valid_r || push_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      phase_r <= phase_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_data  = {classify(phase_r + tpm_pkg::THIRD_TURN),
                       classify(phase_r - tpm_pkg::THIRD_TURN),
                       classify(phase_r)};

endmodule

/* hdl/tpm_queue.sv */
// ---------------------------------------------------------------------------
// tpm_queue: two-entry queue between front and back end
// Lets the phase front end and the sine back end stall independently.
// ---------------------------------------------------------------------------
module tpm_queue #(
  parameter int WIDTH = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push_valid) |=> !pop_valid)
    else $error("queue shows data without a push");

endmodule

/* hdl/tpm_back.sv */
// ---------------------------------------------------------------------------
// tpm_back: sine lookup, scaling, zero-sequence injection and saturation
// Five-stage pipeline that stalls as a whole when the output beat is held.
// ---------------------------------------------------------------------------
module tpm_back #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tpm_pkg::cfg_t               cfg,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [3*SINE_ADDR_BITS-1:0] pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [17:0]          out_cmd_a,
  output logic signed [17:0]          out_cmd_b,
  output logic signed [17:0]          out_cmd_c
);

  localparam int A    = SINE_ADDR_BITS;
  localparam int QLEN = 1 << (A - 2);

  logic [14:0] sine_rom [QLEN+1];

  logic              en;
  logic              v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [14:0]       mag1_r  [3];
  logic              neg1_r  [3];
  logic signed [16:0] base_nxt [3];
  logic signed [16:0] base2_r [3];
  logic signed [16:0] base3_r [3];
  logic signed [16:0] base4_r [3];
  logic signed [16:0] mx_nxt, mn_nxt, mx_r, mn_r;
  logic signed [17:0] delta_nxt, delta_r;
  logic signed [17:0] cmd_nxt [3];
  logic signed [17:0] cmd_r   [3];

  // quarter-wave table, filled at elaboration
  for (genvar k = 0; k <= QLEN; k++) begin : g_rom
    assign sine_rom[k] = tpm_pkg::sine_entry(k, A);
  end

  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;

  // stage 1: table read
  always_ff @(posedge clk) begin
    if (en && pop_valid) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= sine_rom[pop_data[i*A +: A-1]];
        neg1_r[i] <= pop_data[i*A + A-1];
      end
    end
  end

  // stage 2: amplitude scaling, round half away from zero
  always_comb begin
    logic [29:0] prod;
    logic [30:0] rnd;
    logic signed [16:0] p;
    for (int i = 0; i < 3; i++) begin
      prod = mag1_r[i] * cfg.mod_index;
      rnd  = {1'b0, prod} + 31'd8192;
      p    = $signed(rnd[30:14]);
      base_nxt[i] = neg1_r[i] ? -p : p;
    end
  end

  // stage 3: extremes of the three phases
  always_comb begin
    mx_nxt = base2_r[0];
    mn_nxt = base2_r[0];
    for (int i = 1; i < 3; i++) begin
      if (base2_r[i] > mx_nxt) mx_nxt = base2_r[i];
      if (base2_r[i] < mn_nxt) mn_nxt = base2_r[i];
    end
  end

  // stage 4: common-mode offset per mode
  always_comb begin
    logic signed [17:0] sum;
    logic signed [17:0] half;
    logic [16:0]        amx;
    logic [16:0]        amn;
    sum  = 18'(mx_r) + 18'(mn_r);
    half = (sum + (sum < 0 ? 18'sd1 : 18'sd0)) >>> 1;
    amx  = mx_r < 0 ? 17'(-mx_r) : 17'(mx_r);
    amn  = mn_r < 0 ? 17'(-mn_r) : 17'(mn_r);
    unique case (cfg.mod_mode)
      tpm_pkg::MODE_MINMAX: delta_nxt = -half;
      tpm_pkg::MODE_DPWM: begin
        if (amx >= amn) begin
          delta_nxt = $signed({3'b000, tpm_pkg::ONE_Q14}) - 18'(mx_r);
        end else begin
          delta_nxt = -$signed({3'b000, tpm_pkg::ONE_Q14}) - 18'(mn_r);
        end
      end
      default: delta_nxt = 18'sd0;
    endcase
  end

  // stage 5: apply offset and saturate to Q3.14, or force zero in zero mode
  always_comb begin
    logic signed [18:0] s;
    for (int i = 0; i < 3; i++) begin
      s = 19'(base4_r[i]) + 19'(delta_r);
      if (cfg.mod_mode == tpm_pkg::MODE_ZERO) begin
        cmd_nxt[i] = 18'sd0;
      end else if (s > tpm_pkg::CMD_MAX) begin
        cmd_nxt[i] = tpm_pkg::CMD_MAX[17:0];
      end else if (s < tpm_pkg::CMD_MIN) begin
        cmd_nxt[i] = tpm_pkg::CMD_MIN[17:0];
      end else begin
        cmd_nxt[i] = s[17:0];
      end
    end
  end

  // pipeline valids and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
    if (en) begin
      base2_r <= base_nxt;
      base3_r <= base2_r;
      mx_r    <= mx_nxt;
      mn_r    <= mn_nxt;
      base4_r <= base3_r;
      delta_r <= delta_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cmd_a = cmd_r[0];
  assign out_cmd_b = cmd_r[1];
  assign out_cmd_c = cmd_r[2];

  // assertions
  a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cfg.mod_mode == tpm_pkg::MODE_ZERO) |->
      (cmd_r[0] == 18'sd0 && cmd_r[1] == 18'sd0 && cmd_r[2] == 18'sd0))
    else $error("zero mode beat carries nonzero command");

  a_stall_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop_ready)
    else $error("queue popped while output stalled");

endmodule

/* hdl/three_phase_modulation_command.sv */
// ---------------------------------------------------------------------------
// three_phase_modulation_command: three-phase PWM reference generator
// Phase accumulation from a tick, quarter-wave sine lookup, amplitude scaling
// and optional min-max or discontinuous zero-sequence injection.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | in_time_ticks[31:0]
//  out     | output    | out_valid/out_ready  | out_cmd_a/b/c, signed Q3.14
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index[7:0], cfg_data[31:0]
//
//  One beat per clock sustained while out_ready stays high; registers in order:
//  phase multiply, queue, table read, scale multiply, extremes, offset, sat.
//  Synchronous active-low reset clears control state and sets register
//  defaults; the sine table is constant and needs no clearing.
//  A held output freezes the back end; the queue fills to two entries and,
//  with the front also holding a beat, in_ready drops. In steady flow that
//  is one more beat taken after the hold starts. cfg_ready is always high.
// ---------------------------------------------------------------------------
module three_phase_modulation_command #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_time_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_cmd_a,
  output logic signed [17:0] out_cmd_b,
  output logic signed [17:0] out_cmd_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QW = 3 * SINE_ADDR_BITS;

  tpm_pkg::cfg_t cfg_r;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step   <= 32'd0;
      cfg_r.phase_offset <= 16'd0;
      cfg_r.mod_index    <= tpm_pkg::MOD_INDEX_RST;
      cfg_r.mod_mode     <= tpm_pkg::MODE_SINE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpm_pkg::REG_PHASE_STEP:   cfg_r.phase_step   <= cfg_data;
        tpm_pkg::REG_PHASE_OFFSET: cfg_r.phase_offset <= cfg_data[15:0];
        tpm_pkg::REG_MOD_INDEX:    cfg_r.mod_index    <= cfg_data[14:0];
        tpm_pkg::REG_MOD_MODE:     cfg_r.mod_mode     <= tpm_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  tpm_front #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_time_ticks (in_time_ticks),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  tpm_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tpm_back #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cmd_a (out_cmd_a),
    .out_cmd_b (out_cmd_b),
    .out_cmd_c (out_cmd_c)
  );

endmodule
